// ----- src/mts_pkg.sv -----
package mts_pkg;

   localparam int DEFAULT_STACK_DEPTH = 64;
   localparam int VALUE_WIDTH = 32;

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_POP_EMPTY = 2'd1,
      STATUS_PUSH_FULL = 2'd2
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;   // execute the command on the req_ ports
      logic fetch;    // read the new tops out of both stores
      logic load;     // capture the read data into the top registers
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic needs_fetch;   // pending command is a pop that leaves values behind
   } dp_stat_type;

endpackage

// ----- src/mts_ram.sv -----
module mts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/mts_ctrl.sv -----
module mts_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  mts_pkg::dp_stat_type  stat,
   output mts_pkg::ctrl_cmd_type cmd
);
   import mts_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_FETCH = 4'b0010,
      ST_LOAD  = 4'b0100,
      ST_SEND  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd.accept = 1'b0;
      cmd.fetch  = 1'b0;
      cmd.load   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = stat.needs_fetch ? ST_FETCH : ST_SEND;
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_SEND);

endmodule

// ----- src/mts_datapath.sv -----
module mts_datapath #(
   parameter int STACK_DEPTH = mts_pkg::DEFAULT_STACK_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_cmd,
   input  logic signed [mts_pkg::VALUE_WIDTH-1:0] req_value,
   input  mts_pkg::ctrl_cmd_type                cmd,
   output mts_pkg::dp_stat_type                 stat,
   output logic signed [mts_pkg::VALUE_WIDTH-1:0] rsp_top_value,
   output logic signed [mts_pkg::VALUE_WIDTH-1:0] rsp_min_value,
   output logic                                 rsp_is_empty,
   output logic [$clog2(STACK_DEPTH+1)-1:0]     rsp_depth_now,
   output logic [1:0]                           rsp_status
);
   import mts_pkg::*;

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);

   logic [CW-1:0] vcount_ff, vcount_in;
   logic [CW-1:0] mcount_ff, mcount_in;
   logic signed [VALUE_WIDTH-1:0] top_ff, top_in;
   logic signed [VALUE_WIDTH-1:0] min_ff, min_in;
   status_type status_ff, status_in;

   logic                   v_we, m_we;
   logic [AW-1:0]          v_waddr, m_waddr;
   logic [AW-1:0]          v_raddr, m_raddr;
   logic [VALUE_WIDTH-1:0] v_rdata, m_rdata;
   logic                   is_full, is_empty;

   assign is_full  = (vcount_ff == CW'(STACK_DEPTH));
   assign is_empty = (vcount_ff == '0);

   assign stat.needs_fetch = (req_cmd == CMD_POP) && (vcount_ff > CW'(1));

   always_comb begin
      vcount_in = vcount_ff;
      mcount_in = mcount_ff;
      top_in    = top_ff;
      min_in    = min_ff;
      status_in = status_ff;
      v_we      = 1'b0;
      m_we      = 1'b0;
      if (cmd.accept) begin
         status_in = STATUS_OK;
         if (req_cmd == CMD_PUSH) begin
            if (is_full) begin
               status_in = STATUS_PUSH_FULL;
            end else begin
               v_we      = 1'b1;
               vcount_in = vcount_ff + CW'(1);
               top_in    = req_value;
               // equal values go on again so a later pop keeps the minimum
               if (mcount_ff == '0 || req_value <= min_ff) begin
                  m_we      = 1'b1;
                  mcount_in = mcount_ff + CW'(1);
                  min_in    = req_value;
               end
            end
         end else begin
            if (is_empty) begin
               status_in = STATUS_POP_EMPTY;
            end else begin
               vcount_in = vcount_ff - CW'(1);
               if (min_ff == top_ff) begin
                  mcount_in = mcount_ff - CW'(1);
               end
            end
         end
      end else if (cmd.load) begin
         top_in = v_rdata;
         min_in = m_rdata;
      end
   end

   // write at the current count, read just below the (already updated) count
   assign v_waddr = vcount_ff[AW-1:0];
   assign m_waddr = mcount_ff[AW-1:0];
   assign v_raddr = AW'(vcount_ff - CW'(1));
   assign m_raddr = AW'(mcount_ff - CW'(1));

   mts_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (STACK_DEPTH)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (v_we),
      .wr_addr (v_waddr),
      .wr_data (req_value),
      .rd_en   (cmd.fetch),
      .rd_addr (v_raddr),
      .rd_data (v_rdata)
   );

   mts_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (STACK_DEPTH)
   ) u_min_ram (
      .clock   (clock),
      .wr_en   (m_we),
      .wr_addr (m_waddr),
      .wr_data (req_value),
      .rd_en   (cmd.fetch),
      .rd_addr (m_raddr),
      .rd_data (m_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= '0;
         mcount_ff <= '0;
      end else begin
         vcount_ff <= vcount_in;
         mcount_ff <= mcount_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff    <= top_in;
      min_ff    <= min_in;
      status_ff <= status_in;
   end

   assign rsp_top_value = is_empty ? '0 : top_ff;
   assign rsp_min_value = is_empty ? '0 : min_ff;
   assign rsp_is_empty  = is_empty;
   assign rsp_depth_now = vcount_ff;
   assign rsp_status    = status_ff;

endmodule

// ----- src/min_tracking_stack.sv -----
// Channel | Direction | Handshake            | Payload
// req_    | in        | req_valid/req_stall  | req_cmd, req_value
// rsp_    | out       | rsp_valid/rsp_stall  | rsp_top_value, rsp_min_value, rsp_is_empty,
//         |           |                      | rsp_depth_now, rsp_status
//
// One item at a time. A push, a pop that empties the stack, or any command that
// fails has its result offered the cycle after acceptance. A pop that leaves
// values behind goes through fetch and load states before its result is offered:
// the new tops come out of the value and minimum RAMs over their registered read port.
// Synchronous active-high reset empties both stacks; no clearing pass needed.
// A stalled result holds the block; req_stall stays high until it is taken.
module min_tracking_stack #(
   parameter int STACK_DEPTH = mts_pkg::DEFAULT_STACK_DEPTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_cmd,
   input  logic signed [mts_pkg::VALUE_WIDTH-1:0] req_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [mts_pkg::VALUE_WIDTH-1:0] rsp_top_value,
   output logic signed [mts_pkg::VALUE_WIDTH-1:0] rsp_min_value,
   output logic                                   rsp_is_empty,
   output logic [$clog2(STACK_DEPTH+1)-1:0]       rsp_depth_now,
   output logic [1:0]                             rsp_status
);
   import mts_pkg::*;

   ctrl_cmd_type cmd;    // sequencing from the controller
   dp_stat_type  stat;   // pop-needs-read hint from the datapath

   // Controller: idle -> (fetch -> load ->) send.
   mts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath: counts, cached tops of both stacks, two stack RAMs.
   mts_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_cmd       (req_cmd),
      .req_value     (req_value),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_top_value (rsp_top_value),
      .rsp_min_value (rsp_min_value),
      .rsp_is_empty  (rsp_is_empty),
      .rsp_depth_now (rsp_depth_now),
      .rsp_status    (rsp_status)
   );

   // No new item while a result is still pending.
   a_no_accept_while_pending: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> !rsp_valid)
      else $error("item accepted while a result is pending");

   // RAM data is captured only the cycle after the read.
   a_load_follows_fetch: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> $past(cmd.fetch))
      else $error("load without a preceding fetch");

   // An empty stack reports zero for both top and minimum.
   a_empty_reads_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_empty) |-> (rsp_top_value == '0 && rsp_min_value == '0))
      else $error("empty stack with nonzero top or minimum");

   // A failed pop can only come from an empty stack.
   a_pop_error_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_POP_EMPTY) |-> rsp_is_empty)
      else $error("pop error reported on a nonempty stack");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import mts_pkg::*;

   localparam int STACK_DEPTH = DEFAULT_STACK_DEPTH;
   localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
   localparam int VW = VALUE_WIDTH;

   localparam logic signed [VW-1:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [VW-1:0] VAL_MIN = 32'sh8000_0000;

   localparam int RANDOM_ITEMS   = 1800;
   localparam int CALM_TAIL      = 200;   // last items run with no idling at all
   localparam int HOLD_AT_ITEM   = 400;   // receiver goes away for a long stretch here
   localparam int PAUSE_AT_ITEM  = 900;   // sender waits for the block to drain here
   localparam int LONG_HOLD      = 150;   // cycles of the long receiver hold-off
   localparam int DRAIN_CYCLES   = 8;     // settle margin after the last result is checked
   localparam int WATCHDOG_LIMIT = 1000;  // quiet cycles before we call it hung
   localparam int REPORT_LIMIT   = 10;

   // What the stack looks like after one command; one per result item.
   typedef struct packed {
      logic signed [VW-1:0] top;
      logic signed [VW-1:0] minv;
      logic                 empty;
      logic [DEPTH_W-1:0]   depth;
      status_type           status;
   } stack_view_type;

   // Directed row: command, value, and a hand-typed view where it is obvious.
   typedef struct packed {
      logic                 cmd;
      logic signed [VW-1:0] value;
      logic                 typed;
      stack_view_type       view;
   } directed_row_type;

   localparam int ROWS = 23;
   localparam directed_row_type PLAN [ROWS] = '{
      // pop straight out of reset: error, nothing held
      '{CMD_POP,  32'sh0,      1'b1, '{32'sh0, 32'sh0, 1'b1, DEPTH_W'(0), STATUS_POP_EMPTY}},
      // extremes go in; the most negative value becomes the minimum
      '{CMD_PUSH, VAL_MAX,     1'b1, '{VAL_MAX, VAL_MAX, 1'b0, DEPTH_W'(1), STATUS_OK}},
      '{CMD_PUSH, VAL_MIN,     1'b1, '{VAL_MIN, VAL_MIN, 1'b0, DEPTH_W'(2), STATUS_OK}},
      '{CMD_PUSH, 32'sh0,      1'b1, '{32'sh0, VAL_MIN, 1'b0, DEPTH_W'(3), STATUS_OK}},
      // equal to current minimum: a second copy goes on the minimum stack
      '{CMD_PUSH, VAL_MIN,     1'b1, '{VAL_MIN, VAL_MIN, 1'b0, DEPTH_W'(4), STATUS_OK}},
      // pop with junk in the value field; the other copy keeps the minimum
      '{CMD_POP,  -32'sh1,     1'b1, '{32'sh0, VAL_MIN, 1'b0, DEPTH_W'(3), STATUS_OK}},
      '{CMD_POP,  32'sh0,      1'b0, '0},
      '{CMD_POP,  32'sh0,      1'b0, '0},
      '{CMD_POP,  32'sh0,      1'b1, '{32'sh0, 32'sh0, 1'b1, DEPTH_W'(0), STATUS_OK}},
      '{CMD_POP,  VAL_MAX,     1'b1, '{32'sh0, 32'sh0, 1'b1, DEPTH_W'(0), STATUS_POP_EMPTY}},
      // small values: larger value skips the minimum stack, equal one does not
      '{CMD_PUSH, -32'sh1,     1'b0, '0},
      '{CMD_PUSH, 32'sh1,      1'b0, '0},
      '{CMD_PUSH, -32'sh1,     1'b0, '0},
      '{CMD_PUSH, -32'sh2,     1'b0, '0},
      '{CMD_PUSH, 32'sh5555_5555, 1'b0, '0},
      '{CMD_POP,  32'sh0,      1'b0, '0},
      '{CMD_POP,  32'sh0,      1'b0, '0},
      '{CMD_POP,  32'sh0,      1'b0, '0},
      '{CMD_PUSH, 32'shAAAA_AAAA, 1'b0, '0},
      '{CMD_POP,  32'sh0,      1'b0, '0},
      '{CMD_POP,  32'sh0,      1'b0, '0},
      '{CMD_POP,  32'sh0,      1'b0, '0},
      '{CMD_POP,  32'sh0,      1'b1, '{32'sh0, 32'sh0, 1'b1, DEPTH_W'(0), STATUS_POP_EMPTY}}
   };

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic                 req_cmd;
   logic signed [VW-1:0] req_value;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic signed [VW-1:0] rsp_top_value;
   logic signed [VW-1:0] rsp_min_value;
   logic                 rsp_is_empty;
   logic [DEPTH_W-1:0]   rsp_depth_now;
   logic [1:0]           rsp_status;

   min_tracking_stack #(.STACK_DEPTH(STACK_DEPTH)) uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd       (req_cmd),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_top_value (rsp_top_value),
      .rsp_min_value (rsp_min_value),
      .rsp_is_empty  (rsp_is_empty),
      .rsp_depth_now (rsp_depth_now),
      .rsp_status    (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Shadow stack: value stack plus stack of running minimums.
   // ------------------------------------------------------------------
   logic signed [VW-1:0] shadow_vals [STACK_DEPTH];
   logic signed [VW-1:0] shadow_mins [STACK_DEPTH];
   int shadow_count = 0;
   int min_count = 0;

   // run statistics for the summary
   int push_total = 0;
   int pop_total = 0;
   int full_hits = 0;
   int empty_hits = 0;
   int peak_depth = 0;

   stack_view_type expected_views [$];

   // Apply one accepted command to the shadow stack and return the view after it.
   function automatic stack_view_type apply_command(input logic cmd,
                                                    input logic signed [VW-1:0] value);
      stack_view_type view;
      view.status = STATUS_OK;
      if (cmd == CMD_PUSH) begin
         push_total++;
         if (shadow_count >= STACK_DEPTH) begin
            view.status = STATUS_PUSH_FULL;
            full_hits++;
         end else begin
            shadow_vals[shadow_count] = value;
            shadow_count++;
            // ties go on the minimum stack too, so one pop can't lose the minimum
            if (min_count == 0 || value <= shadow_mins[min_count-1]) begin
               shadow_mins[min_count] = value;
               min_count++;
            end
         end
      end else begin
         pop_total++;
         if (shadow_count == 0) begin
            view.status = STATUS_POP_EMPTY;
            empty_hits++;
         end else begin
            shadow_count--;
            if (shadow_mins[min_count-1] == shadow_vals[shadow_count])
               min_count--;
         end
      end
      if (shadow_count > peak_depth)
         peak_depth = shadow_count;
      view.top   = (shadow_count > 0) ? shadow_vals[shadow_count-1] : '0;
      view.minv  = (shadow_count > 0) ? shadow_mins[min_count-1] : '0;
      view.empty = (shadow_count == 0);
      view.depth = shadow_count[DEPTH_W-1:0];
      return view;
   endfunction

   // ------------------------------------------------------------------
   // Sender. Payload changes on the falling edge; the item is taken at the
   // first rising edge that sees req_stall low. The shadow stack advances
   // right there, so the expectation queue stays in acceptance order.
   // ------------------------------------------------------------------
   int items_sent = 0;

   task automatic offer(input logic cmd, input logic signed [VW-1:0] value,
                        input logic typed, input stack_view_type typed_view);
      stack_view_type view;
      @(negedge clock);
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      view = apply_command(cmd, value);
      expected_views.push_back(typed ? typed_view : view);
      items_sent++;
   endtask

   // Drop valid for a burst of cycles; one assignment per falling edge.
   task automatic sender_gap(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   // ------------------------------------------------------------------
   // Receiver. Random stall bursts, one long hold-off on request, and nothing
   // at all in calm epochs or once the calm tail starts.
   // ------------------------------------------------------------------
   bit tail_calm = 1'b0;     // final stretch: no idling on either side
   bit epoch_calm = 1'b0;    // current random epoch runs with no idling
   bit hold_off_req = 1'b0;  // sender asks for the long hold-off

   initial begin : receiver
      int hold_left;
      int burst_left;
      hold_left = 0;
      burst_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req && hold_left == 0) begin
            hold_off_req = 1'b0;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (burst_left > 0) begin
            burst_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if (!tail_calm && !epoch_calm && $urandom_range(0, 6) == 0)
               burst_left = $urandom_range(1, 9);
         end
      end
   end

   // ------------------------------------------------------------------
   // Result checker: every taken result against the oldest expectation.
   // ------------------------------------------------------------------
   int fail_count = 0;
   int results_seen = 0;
   stack_view_type oldest;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_views.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display("unexpected result: top %0d min %0d empty %0d depth %0d status %0d",
                        rsp_top_value, rsp_min_value, rsp_is_empty, rsp_depth_now,
                        rsp_status);
         end else begin
            oldest = expected_views.pop_front();
            if (rsp_top_value !== oldest.top || rsp_min_value !== oldest.minv ||
                rsp_is_empty !== oldest.empty || rsp_depth_now !== oldest.depth ||
                rsp_status !== oldest.status) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT) begin
                  $display("result %0d mismatch:", results_seen);
                  $display("  expected top %0d min %0d empty %0d depth %0d status %0d",
                           oldest.top, oldest.minv, oldest.empty, oldest.depth,
                           oldest.status);
                  $display("  actual   top %0d min %0d empty %0d depth %0d status %0d",
                           rsp_top_value, rsp_min_value, rsp_is_empty, rsp_depth_now,
                           rsp_status);
               end
            end
         end
      end
   end

   // Watchdog: too many cycles with no handshake on either channel.
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no progress for %0d cycles, %0d results outstanding",
                  quiet_cycles, expected_views.size());
         $display("[min_tracking_stack] ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------
   initial begin : main
      int sent_random;
      int epoch_left;
      int push_pct;
      int pick;
      logic cmd;
      logic signed [VW-1:0] value;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_cmd   = CMD_PUSH;
      req_value = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed rows, back to back
      for (int r = 0; r < ROWS; r++)
         offer(PLAN[r].cmd, PLAN[r].value, PLAN[r].typed, PLAN[r].view);

      // Random part in epochs: fill-heavy epochs run the stack into its full
      // limit, drain-heavy ones into the empty error, balanced ones hover.
      sent_random = 0;
      epoch_left = 0;
      push_pct = 50;
      while (sent_random < RANDOM_ITEMS) begin
         if (epoch_left == 0) begin
            epoch_left = $urandom_range(20, 120);
            case ($urandom_range(0, 3))
               0: push_pct = 90;
               1: push_pct = 12;
               2: push_pct = 55;
               default: push_pct = $urandom_range(0, 100);
            endcase
            epoch_calm = ($urandom_range(0, 3) == 0);
         end
         epoch_left--;

         if (sent_random == RANDOM_ITEMS - CALM_TAIL)
            tail_calm = 1'b1;
         if (sent_random == HOLD_AT_ITEM)
            hold_off_req = 1'b1;
         if (sent_random == PAUSE_AT_ITEM) begin
            // sender goes quiet until every result is back
            sender_gap(1);
            while (expected_views.size() != 0) @(posedge clock);
         end

         cmd = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
         // value mix: extremes, a tiny range full of ties, and full random bits
         pick = $urandom_range(0, 9);
         if (pick < 2) begin
            case ($urandom_range(0, 3))
               0: value = VAL_MIN;
               1: value = VAL_MAX;
               2: value = '0;
               default: value = -32'sh1;
            endcase
         end else if (pick < 5)
            value = $signed($urandom_range(0, 6)) - 32'sd3;
         else
            value = $urandom;

         offer(cmd, value, 1'b0, '0);
         sent_random++;

         if (!tail_calm && !epoch_calm && $urandom_range(0, 5) == 0)
            sender_gap($urandom_range(1, 9));
      end

      // wind down: stop offering, wait for the last results, then settle
      sender_gap(1);
      while (expected_views.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("ran %0d commands (%0d push, %0d pop), peak depth %0d of %0d",
               items_sent, push_total, pop_total, peak_depth, STACK_DEPTH);
      $display("  %0d pushes on a full stack, %0d pops on an empty one, %0d results checked",
               full_hits, empty_hits, results_seen);
      if (fail_count == 0 && expected_views.size() == 0) begin
         $display("[min_tracking_stack] OK");
      end else begin
         $display("%0d failures", fail_count);
         $display("[min_tracking_stack] ERROR");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
src/mts_pkg.sv
src/mts_ram.sv
src/mts_ctrl.sv
src/mts_datapath.sv
src/min_tracking_stack.sv
test/tb.sv
